>>> src/spws_pkg.sv
package spws_pkg;

  localparam int MAX_VERTICES_DEF   = 1024;
  localparam int MAX_EDGE_SLOTS_DEF = 4096;
  localparam int NODE_W             = 11;
  localparam int LEN_W              = 16;
  localparam int WGT_W              = 16;
  localparam int DIST_W             = 32;
  localparam int TOTAL_W            = 63;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_EDGE   = 2'd1,
    REQ_WEIGHT = 2'd2,
    REQ_RUN    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_UNREACH  = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [LEN_W-1:0]  edge_weight;
    logic [WGT_W-1:0]  vertex_weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_ADD0, ST_ADD1, ST_ADD2, ST_RINIT,
    ST_POP, ST_POPW, ST_U, ST_E, ST_EW, ST_T, ST_SR, ST_SM, ST_SA, ST_OUT
  } state_t;

endpackage

>>> src/spws_ram.sv
module spws_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/shortest_path_weighted_sum.sv
// Shortest-path weighted sum engine.
// Input channel in_valid/in_ready/in_data carries one item: clear graph,
// add undirected edge, set vertex weight or run. Only a run item gives a
// result on out_valid/out_ready/out_data: status and weighted total.
// cfg_we/cfg_wdata write vertex_count; the user must do this only
// while the block is idle, as the block does not enforce it. in_ready
// is low while an item is in work: set weight is done in ST_IDLE, add
// edge steps ST_ADD0 to ST_ADD2, clear zeroes every list head, and a
// run resets the distance table, then steps ST_POP, ST_POPW, ST_U per
// dequeued vertex, ST_E, ST_EW, ST_T per scanned edge and ST_SR, ST_SM,
// ST_SA per summed vertex; after an edge overflow it answers directly.
// After reset list heads and vertex weights clear before in_ready rises.
// A result waits in an output register; if the receiver stalls, later load
// items are still taken, and a finished run holds until the register frees.
module shortest_path_weighted_sum #(
  parameter int MAX_VERTICES   = spws_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGE_SLOTS = spws_pkg::MAX_EDGE_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  spws_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output spws_pkg::out_item_t     out_data,
  input  logic                    cfg_we,
  input  logic [spws_pkg::NODE_W-1:0] cfg_wdata
);
  import spws_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGE_SLOTS);
  localparam int HW  = $clog2(MAX_EDGE_SLOTS + 1);
  localparam int EDW = HW + VW + LEN_W;
  localparam int VSW = DIST_W + 2;
  localparam int PW  = WGT_W + DIST_W;

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [NODE_W-1:0] vcnt_r, vcnt_nxt;
  logic [HW-1:0] fill_r, fill_nxt;
  logic ovf_r, ovf_nxt;
  logic [VW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] u_r, u_nxt, t_r, t_nxt;
  logic [DIST_W-1:0] du_r, du_nxt;
  logic [HW-1:0] link_r, link_nxt, next_r, next_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [TOTAL_W-1:0] sum_r, sum_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic lh_we, vw_we, ed_we, vs_we, rg_we;
  logic [VW-1:0] lh_wa, lh_ra, vw_wa, vw_ra, vs_wa, vs_ra, rg_wa, rg_ra;
  logic [HW-1:0] lh_wd, lh_rd;
  logic [WGT_W-1:0] vw_wd, vw_rd;
  logic [EW-1:0] ed_wa, ed_ra;
  logic [EDW-1:0] ed_wd, ed_rd;
  logic [VSW-1:0] vs_wd, vs_rd;
  logic [VW-1:0] rg_wd, rg_rd;

  logic [NW-1:0] n_lim;
  logic bad_a, bad_b;
  logic [VW-1:0] a_ix, b_ix;
  logic [DIST_W-1:0] d_new;
  logic enq;

  spws_ram #(.DEPTH(MAX_VERTICES), .WIDTH(HW)) u_lh (
    .clk(clk), .we(lh_we), .waddr(lh_wa), .wdata(lh_wd), .raddr(lh_ra), .rdata(lh_rd));
  spws_ram #(.DEPTH(MAX_VERTICES), .WIDTH(WGT_W)) u_vw (
    .clk(clk), .we(vw_we), .waddr(vw_wa), .wdata(vw_wd), .raddr(vw_ra), .rdata(vw_rd));
  spws_ram #(.DEPTH(MAX_EDGE_SLOTS), .WIDTH(EDW)) u_ed (
    .clk(clk), .we(ed_we), .waddr(ed_wa), .wdata(ed_wd), .raddr(ed_ra), .rdata(ed_rd));
  spws_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VSW)) u_vs (
    .clk(clk), .we(vs_we), .waddr(vs_wa), .wdata(vs_wd), .raddr(vs_ra), .rdata(vs_rd));
  spws_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_rg (
    .clk(clk), .we(rg_we), .waddr(rg_wa), .wdata(rg_wd), .raddr(rg_ra), .rdata(rg_rd));

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_lim = (32'(vcnt_r) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      vcnt_r      <= NODE_W'(1);
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    u_r        <= u_nxt;
    t_r        <= t_nxt;
    du_r       <= du_nxt;
    link_r     <= link_nxt;
    next_r     <= next_nxt;
    len_r      <= len_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    vcnt_nxt      = cfg_we ? cfg_wdata : vcnt_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    u_nxt         = u_r;
    t_nxt         = t_r;
    du_nxt        = du_r;
    link_nxt      = link_r;
    next_nxt      = next_r;
    len_nxt       = len_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;

    lh_we = 1'b0; lh_wa = '0; lh_wd = '0; lh_ra = '0;
    vw_we = 1'b0; vw_wa = '0; vw_wd = '0; vw_ra = '0;
    ed_we = 1'b0; ed_wa = '0; ed_wd = '0; ed_ra = '0;
    vs_we = 1'b0; vs_wa = '0; vs_wd = '0; vs_ra = '0;
    rg_we = 1'b0; rg_wa = '0; rg_wd = '0; rg_ra = '0;

    bad_a = (in_data.node_a == '0) || (32'(in_data.node_a) > 32'(MAX_VERTICES));
    bad_b = (in_data.node_b == '0) || (32'(in_data.node_b) > 32'(MAX_VERTICES));
    a_ix  = VW'(item_r.node_a - NODE_W'(1));
    b_ix  = VW'(item_r.node_b - NODE_W'(1));
    d_new = du_r + DIST_W'(len_r);
    enq   = 1'b0;

    case (state_r)
      ST_INIT: begin
        lh_we = 1'b1; lh_wa = idx_r;
        vw_we = 1'b1; vw_wa = idx_r;
        idx_nxt = idx_r + VW'(1);
        if (32'(idx_r) == MAX_VERTICES - 1) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.req_type)
            REQ_CLEAR: begin
              fill_nxt  = '0;
              ovf_nxt   = 1'b0;
              idx_nxt   = '0;
              state_nxt = ST_CLR;
            end
            REQ_EDGE: begin
              if (!bad_a && !bad_b) begin
                if (32'(fill_r) + 2 > MAX_EDGE_SLOTS) begin
                  ovf_nxt = 1'b1;
                end else begin
                  state_nxt = ST_ADD0;
                end
              end
            end
            REQ_WEIGHT: begin
              if (!bad_a) begin
                vw_we = 1'b1;
                vw_wa = VW'(in_data.node_a - NODE_W'(1));
                vw_wd = in_data.vertex_weight;
              end
            end
            default: begin
              if (ovf_r) begin
                res_nxt   = '{status: STAT_OVERFLOW, total: '0};
                state_nxt = ST_OUT;
              end else begin
                idx_nxt   = '0;
                sum_nxt   = '0;
                state_nxt = ST_RINIT;
              end
            end
          endcase
        end
      end
      ST_CLR: begin
        lh_we = 1'b1; lh_wa = idx_r;
        idx_nxt = idx_r + VW'(1);
        if (32'(idx_r) == MAX_VERTICES - 1) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD0: begin
        lh_ra     = a_ix;
        state_nxt = ST_ADD1;
      end
      ST_ADD1: begin
        ed_we = 1'b1; ed_wa = EW'(fill_r);
        ed_wd = {lh_rd, b_ix, item_r.edge_weight};
        lh_we = 1'b1; lh_wa = a_ix; lh_wd = fill_r + HW'(1);
        lh_ra = b_ix;
        state_nxt = ST_ADD2;
      end
      ST_ADD2: begin
        // self loop: second list head is the slot just written
        ed_we = 1'b1; ed_wa = EW'(fill_r + HW'(1));
        ed_wd = {(a_ix == b_ix) ? fill_r + HW'(1) : lh_rd, a_ix, item_r.edge_weight};
        lh_we = 1'b1; lh_wa = b_ix; lh_wd = fill_r + HW'(2);
        fill_nxt  = fill_r + HW'(2);
        state_nxt = ST_IDLE;
      end
      ST_RINIT: begin
        vs_we = 1'b1; vs_wa = idx_r;
        vs_wd = (idx_r == '0) ? {2'b11, DIST_W'(0)} : '0;
        idx_nxt = idx_r + VW'(1);
        if (32'(idx_r) == MAX_VERTICES - 1) begin
          rg_we     = 1'b1; rg_wa = '0; rg_wd = '0;
          idx_nxt   = '0;
          head_nxt  = '0;
          tail_nxt  = VW'(1);
          cnt_nxt   = NW'(1);
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (cnt_r == '0) begin
          if (n_lim == '0) begin
            res_nxt   = '{status: STAT_OK, total: '0};
            state_nxt = ST_OUT;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_SR;
          end
        end else begin
          rg_ra     = head_r;
          head_nxt  = (32'(head_r) == MAX_VERTICES - 1) ? '0 : head_r + VW'(1);
          cnt_nxt   = cnt_r - NW'(1);
          state_nxt = ST_POPW;
        end
      end
      ST_POPW: begin
        u_nxt     = rg_rd;
        vs_ra     = rg_rd;
        lh_ra     = rg_rd;
        state_nxt = ST_U;
      end
      ST_U: begin
        vs_we = 1'b1; vs_wa = u_r; vs_wd = {1'b0, vs_rd[VSW-2:0]};
        du_nxt   = vs_rd[DIST_W-1:0];
        link_nxt = lh_rd;
        state_nxt = (lh_rd == '0) ? ST_POP : ST_E;
      end
      ST_E: begin
        ed_ra     = EW'(link_r - HW'(1));
        state_nxt = ST_EW;
      end
      ST_EW: begin
        next_nxt  = ed_rd[EDW-1 -: HW];
        t_nxt     = ed_rd[LEN_W +: VW];
        len_nxt   = ed_rd[LEN_W-1:0];
        vs_ra     = ed_rd[LEN_W +: VW];
        state_nxt = ST_T;
      end
      ST_T: begin
        if (!vs_rd[DIST_W] || (vs_rd[DIST_W-1:0] > d_new)) begin
          enq   = !vs_rd[DIST_W+1] && (32'(cnt_r) < MAX_VERTICES);
          vs_we = 1'b1; vs_wa = t_r;
          vs_wd = {vs_rd[DIST_W+1] | enq, 1'b1, d_new};
          if (t_r == u_r) begin
            du_nxt = d_new;
          end
          if (enq) begin
            rg_we    = 1'b1; rg_wa = tail_r; rg_wd = t_r;
            tail_nxt = (32'(tail_r) == MAX_VERTICES - 1) ? '0 : tail_r + VW'(1);
            cnt_nxt  = cnt_r + NW'(1);
          end
        end
        link_nxt  = next_r;
        state_nxt = (next_r == '0) ? ST_POP : ST_E;
      end
      ST_SR: begin
        vs_ra     = idx_r;
        vw_ra     = idx_r;
        state_nxt = ST_SM;
      end
      ST_SM: begin
        if (!vs_rd[DIST_W]) begin
          res_nxt   = '{status: STAT_UNREACH, total: '0};
          state_nxt = ST_OUT;
        end else begin
          prod_nxt  = PW'(vw_rd) * PW'(vs_rd[DIST_W-1:0]);
          state_nxt = ST_SA;
        end
      end
      ST_SA: begin
        sum_nxt = sum_r + TOTAL_W'(prod_r);
        if (NW'(idx_r) + NW'(1) == n_lim) begin
          res_nxt   = '{status: STAT_OK, total: sum_r + TOTAL_W'(prod_r)};
          state_nxt = ST_OUT;
        end else begin
          idx_nxt   = idx_r + VW'(1);
          state_nxt = ST_SR;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
